FILE: src/tga_rle_pixel_decoder_defines.svh
// assertion macros for the tga rle pixel decoder rtl
// no dependencies; included by files that carry concurrent checks
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TGARLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tgarle check failed");

// next-cycle implication, disabled during reset
`define TGARLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tgarle check failed");

`endif

FILE: src/tgarle_pkg.sv
// types, constants and helper functions for the tga rle pixel decoder
// no dependencies; used by tgarle_regs, tgarle_step and the top level
package tgarle_pkg;

	// apb address width: three 32-bit registers at 0, 4, 8
	localparam int ADDR_W = 4;

	// register indexes
	localparam logic [1:0] REG_BPP   = 2'd0;
	localparam logic [1:0] REG_TOTAL = 2'd1;
	localparam logic [1:0] REG_RLE   = 2'd2;

	// register reset values
	localparam logic [2:0]  BPP_RESET   = 3'd4;
	localparam logic [31:0] TOTAL_RESET = 32'd1;
	localparam logic        RLE_RESET   = 1'b0;

	// packet head fields
	localparam logic [7:0] RUN_MASK    = 8'h7f;
	localparam logic [7:0] REPEAT_FLAG = 8'h80;

	// source byte lane for each output lane of a bgr(a) pixel
	localparam logic [1:0] LANE_SRC [4] = '{2'd2, 2'd1, 2'd0, 2'd3};

	typedef struct packed {
		logic [2:0]  bytes_per_pixel;
		logic [31:0] pixel_total;
		logic        rle_mode;
	} cfg_t;

	typedef struct packed {
		logic [31:0] pixel_value;
		logic [7:0]  repeat_count;
		logic        image_end;
		logic        run_clamped;
	} res_t;

	// effective depth: zero acts as one, above four acts as four
	function automatic logic [2:0] depth_of(input logic [2:0] bpp);
		logic [2:0] d;
		d = bpp;
		if (bpp == 3'd0) begin
			d = 3'd1;
		end else if (bpp > 3'd4) begin
			d = 3'd4;
		end
		return d;
	endfunction

	// bgr(a) to rgb(a); grey and two-byte pixels pass straight through
	function automatic logic [31:0] reorder(input logic [31:0] a, input logic [2:0] d);
		logic [31:0] r;
		r = '0;
		if (d == 3'd1) begin
			r = {24'd0, a[7:0]};
		end else if (d == 3'd2) begin
			r = {16'd0, a[15:0]};
		end else begin
			for (int k = 0; k < 4; k++) begin
				if (k < int'(d)) begin
					r[8*k +: 8] = a[8*LANE_SRC[k] +: 8];
				end
			end
		end
		return r;
	endfunction

endpackage

FILE: src/tgarle_regs.sv
// apb configuration registers of the tga rle pixel decoder
// depends on tgarle_pkg
module tgarle_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tgarle_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output tgarle_pkg::cfg_t              cfg
);

	logic [1:0]       idx;
	logic             wr_en;
	tgarle_pkg::cfg_t cfg_q;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes in the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bytes_per_pixel <= tgarle_pkg::BPP_RESET;
			cfg_q.pixel_total     <= tgarle_pkg::TOTAL_RESET;
			cfg_q.rle_mode        <= tgarle_pkg::RLE_RESET;
		end else if (wr_en) begin
			unique case (idx)
				tgarle_pkg::REG_BPP:   cfg_q.bytes_per_pixel <= pwdata[2:0];
				tgarle_pkg::REG_TOTAL: cfg_q.pixel_total     <= pwdata;
				tgarle_pkg::REG_RLE:   cfg_q.rle_mode        <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			tgarle_pkg::REG_BPP:   prdata = {29'd0, cfg_q.bytes_per_pixel};
			tgarle_pkg::REG_TOTAL: prdata = cfg_q.pixel_total;
			tgarle_pkg::REG_RLE:   prdata = {31'd0, cfg_q.rle_mode};
			default:               prdata = 32'd0;
		endcase
	end

endmodule

FILE: src/tgarle_step.sv
// decoder state and the single-pass update for one pixel-data byte
// depends on tgarle_pkg and tga_rle_pixel_decoder_defines.svh
`include "tga_rle_pixel_decoder_defines.svh"

module tgarle_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [7:0]       byte_s1,
	input  tgarle_pkg::cfg_t cfg,
	output logic             res_valid,
	output tgarle_pkg::res_t res
);

	logic        eph_q;
	logic        rep_q;
	logic [7:0]  ppl_q;
	logic [1:0]  bip_q;
	logic [31:0] asm_q;
	logic [31:0] ipl_q;
	logic        clamp_q;

	logic        eph_c;
	logic        rep_c;
	logic [7:0]  ppl_c;
	logic [1:0]  bip_c;
	logic [31:0] asm_c;
	logic [31:0] ipl_c;
	logic        clamp_c;

	logic [2:0]  depth;
	logic [31:0] asm_g;
	logic [1:0]  bip_g;
	logic        done;
	logic [7:0]  run;
	logic [7:0]  cnt;
	logic        out_clamp;
	logic        emit;

	assign depth = tgarle_pkg::depth_of(cfg.bytes_per_pixel);

	// next state and result for the byte in the input register
	always_comb begin
		eph_c     = eph_q;
		rep_c     = rep_q;
		ppl_c     = ppl_q;
		bip_c     = bip_q;
		asm_c     = asm_q;
		ipl_c     = ipl_q;
		clamp_c   = clamp_q;
		emit      = 1'b0;
		cnt       = 8'd1;
		out_clamp = 1'b0;
		run       = 8'd0;

		// image start: load the pixel count and drop packet state
		if (ipl_q == 32'd0) begin
			ipl_c   = (cfg.pixel_total == 32'd0) ? 32'd1 : cfg.pixel_total;
			eph_c   = 1'b1;
			rep_c   = 1'b0;
			ppl_c   = 8'd0;
			clamp_c = 1'b0;
			bip_c   = 2'd0;
		end

		// byte gathering into the pixel
		asm_g = asm_c;
		asm_g[8*bip_c +: 8] = byte_s1;
		done  = ({1'b0, bip_c} + 3'd1) >= depth;
		bip_g = done ? 2'd0 : bip_c + 2'd1;

		if (!cfg.rle_mode) begin
			// uncompressed: every pixel once
			eph_c   = 1'b1;
			rep_c   = 1'b0;
			ppl_c   = 8'd0;
			clamp_c = 1'b0;
			asm_c   = asm_g;
			bip_c   = bip_g;
			emit    = done;
		end else if (eph_c) begin
			// packet head: run length, clamped to the pixels left
			run = (byte_s1 & tgarle_pkg::RUN_MASK) + 8'd1;
			if ({24'd0, run} > ipl_c) begin
				clamp_c = 1'b1;
				run     = ipl_c[7:0];
			end else begin
				clamp_c = 1'b0;
			end
			ppl_c = run;
			rep_c = (byte_s1 & tgarle_pkg::REPEAT_FLAG) != 8'd0;
			eph_c = 1'b0;
			bip_c = 2'd0;
		end else begin
			// packet body
			asm_c = asm_g;
			bip_c = bip_g;
			emit  = done;
			if (done) begin
				cnt = rep_c ? ppl_c : 8'd1;
				if (cnt == 8'd0) begin
					cnt = 8'd1;
				end
				if ({24'd0, cnt} > ipl_c) begin
					cnt = ipl_c[7:0];
				end
				ppl_c = (ppl_c > cnt) ? ppl_c - cnt : 8'd0;
				if (ppl_c == 8'd0) begin
					eph_c = 1'b1;
				end
				out_clamp = clamp_c;
			end
		end

		// count the pixels off and close the image at its last one
		if (emit) begin
			ipl_c = ipl_c - {24'd0, cnt};
			if (ipl_c == 32'd0) begin
				eph_c   = 1'b1;
				rep_c   = 1'b0;
				ppl_c   = 8'd0;
				clamp_c = 1'b0;
				bip_c   = 2'd0;
			end
		end

		res_valid       = step_en && emit;
		res.pixel_value = tgarle_pkg::reorder(asm_c, depth);
		res.repeat_count = cnt;
		res.image_end   = ipl_c == 32'd0;
		res.run_clamped = out_clamp;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eph_q   <= 1'b1;
			rep_q   <= 1'b0;
			ppl_q   <= 8'd0;
			bip_q   <= 2'd0;
			asm_q   <= 32'd0;
			ipl_q   <= 32'd0;
			clamp_q <= 1'b0;
		end else if (step_en) begin
			eph_q   <= eph_c;
			rep_q   <= rep_c;
			ppl_q   <= ppl_c;
			bip_q   <= bip_c;
			asm_q   <= asm_c;
			ipl_q   <= ipl_c;
			clamp_q <= clamp_c;
		end
	end

	// inside a packet there is always a pixel left to come
	`TGARLE_ASSERT_NOW(a_packet_not_empty, clk, arst_n, !eph_q, ppl_q != 8'd0)
	// between images no packet is open
	`TGARLE_ASSERT_NOW(a_idle_expects_head, clk, arst_n, ipl_q == 32'd0, eph_q && !clamp_q)
	// a word never covers zero or more than one packet of pixels
	`TGARLE_ASSERT_NOW(a_count_range, clk, arst_n, res_valid,
		res.repeat_count != 8'd0 && res.repeat_count <= 8'd128)

endmodule

FILE: src/tga_rle_pixel_decoder.sv
// tga rle pixel decoder, top level
// the block takes the pixel-data bytes of a tga image, one word per byte, on
// the input channel (in_valid, in_stall, data_byte) and gives decoded pixels
// on the output channel (out_valid, out_stall, pixel_value, repeat_count,
// image_end, run_clamped). a word moves when valid is high and stall is low.
// depth, pixel count and rle mode come from an apb register port (0x0, 0x4,
// 0x8). the user must write them while the block is idle; it does not check.
// a byte in the byte register has its word registered in the result register
// once that register can advance. throughput is one byte per cycle unless the
// receiver stalls; the state update is short logic between the two registers,
// so bytes follow back to back. packet heads and partial pixels give no word.
// when the receiver stalls, the result register holds its word; the byte
// register still takes one byte while it is empty, after which in_stall
// rises and the accepted byte waits. nothing is dropped.
// reset clears all decoder state; the first byte then starts a new image.
// depends on tgarle_pkg, tgarle_regs and tgarle_step
module tga_rle_pixel_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [31:0]                   pixel_value,
	output logic [7:0]                    repeat_count,
	output logic                          image_end,
	output logic                          run_clamped,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tgarle_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	tgarle_pkg::cfg_t cfg;
	tgarle_pkg::res_t res;
	tgarle_pkg::res_t res_s2;
	logic             res_valid;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             valid_s2;
	logic             advance;

	// configuration registers
	tgarle_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// flow control between the byte and result registers
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// decoder state and single-pass update
	tgarle_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (valid_s1 && advance),
		.byte_s1   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign pixel_value  = res_s2.pixel_value;
	assign repeat_count = res_s2.repeat_count;
	assign image_end    = res_s2.image_end;
	assign run_clamped  = res_s2.run_clamped;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the tga rle pixel decoder: directed bytes, then random packet streams
// a scoreboard class tracks decoder state and checks every pixel word; depends on tgarle_pkg
module testbench;

	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 300;

	// tracks the decoder state and holds the pixel words still to come
	class rle_pixel_board;
		logic [2:0]  bpp;
		logic [31:0] total;
		logic        rle;
		bit          want_head;
		bit          run_repeat;
		int unsigned run_left;
		logic [1:0]  lane;
		logic [31:0] gathered;
		logic [31:0] pixels_left;
		bit          run_cut;
		tgarle_pkg::res_t pixels_due[$];
		int          mismatches;

		function new();
			bpp = tgarle_pkg::BPP_RESET;
			total = tgarle_pkg::TOTAL_RESET;
			rle = tgarle_pkg::RLE_RESET;
			want_head = 1'b1;
			run_repeat = 1'b0;
			run_left = 0;
			lane = 2'd0;
			gathered = '0;
			pixels_left = '0;
			run_cut = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(input logic [1:0] idx, input logic [31:0] value);
			case (idx)
				tgarle_pkg::REG_BPP: bpp = value[2:0];
				tgarle_pkg::REG_TOTAL: total = value;
				tgarle_pkg::REG_RLE: rle = value[0];
				default: ;
			endcase
		endfunction

		// zero acts as grey, anything past four as four
		function int unsigned depth();
			if (bpp == 3'd0) return 1;
			if (bpp > 3'd4) return 4;
			return int'(bpp);
		endfunction

		function bit head_due();
			return want_head || pixels_left == 0;
		endfunction

		function void drop_packet();
			want_head = 1'b1;
			run_repeat = 1'b0;
			run_left = 0;
			run_cut = 1'b0;
		endfunction

		// place a byte in its lane; true once the pixel is whole
		function bit add_byte(input logic [7:0] b);
			int idx;
			idx = int'(lane);
			gathered[8*idx +: 8] = b;
			if (idx + 1 >= depth()) begin
				lane = 2'd0;
				return 1'b1;
			end
			lane = 2'(idx + 1);
			return 1'b0;
		endfunction

		// stored b,g,r(,a) becomes r,g,b(,a); one and two bytes pass straight
		function logic [31:0] to_rgb();
			logic [31:0] r;
			r = '0;
			case (depth())
				1: r[7:0] = gathered[7:0];
				2: r[15:0] = gathered[15:0];
				default: begin
					r[7:0] = gathered[23:16];
					r[15:8] = gathered[15:8];
					r[23:16] = gathered[7:0];
					if (depth() == 4) r[31:24] = gathered[31:24];
				end
			endcase
			return r;
		endfunction

		function void take_byte(input logic [7:0] b);
			int unsigned run;
			int unsigned count;
			bit cut;
			// a fresh image loads its size and forgets any packet
			if (pixels_left == 0) begin
				pixels_left = (total == 0) ? 32'd1 : total;
				drop_packet();
				lane = 2'd0;
			end
			if (!rle) begin
				drop_packet();
				if (!add_byte(b)) return;
				count = 1;
				cut = 1'b0;
			end else if (want_head) begin
				run = int'(b & tgarle_pkg::RUN_MASK) + 1;
				run_cut = run > pixels_left;
				if (run_cut) run = pixels_left;
				run_left = run;
				run_repeat = (b & tgarle_pkg::REPEAT_FLAG) != 8'd0;
				want_head = 1'b0;
				lane = 2'd0;
				return;
			end else begin
				if (!add_byte(b)) return;
				count = run_repeat ? run_left : 1;
				if (count == 0) count = 1;
				if (count > pixels_left) count = pixels_left;
				run_left = (run_left > count) ? run_left - count : 0;
				if (run_left == 0) want_head = 1'b1;
				cut = run_cut;
			end
			pixels_left -= count;
			pixels_due.push_back({to_rgb(), 8'(count), pixels_left == 0, cut});
			if (pixels_left == 0) begin
				drop_packet();
				lane = 2'd0;
			end
		endfunction

		function void check_pixel(input tgarle_pkg::res_t got);
			tgarle_pkg::res_t want;
			if (pixels_due.size() == 0) begin
				$error("pixel word with none expected: pixel_value %h", got.pixel_value);
				mismatches++;
				return;
			end
			want = pixels_due.pop_front();
			if (got.pixel_value !== want.pixel_value) begin
				$error("pixel_value: expected %h, got %h", want.pixel_value, got.pixel_value);
				mismatches++;
			end
			if (got.repeat_count !== want.repeat_count) begin
				$error("repeat_count: expected %0d, got %0d", want.repeat_count, got.repeat_count);
				mismatches++;
			end
			if (got.image_end !== want.image_end) begin
				$error("image_end: expected %b, got %b", want.image_end, got.image_end);
				mismatches++;
			end
			if (got.run_clamped !== want.run_clamped) begin
				$error("run_clamped: expected %b, got %b", want.run_clamped, got.run_clamped);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        data_byte;
	logic              out_valid;
	logic              out_stall;
	logic [31:0]       pixel_value;
	logic [7:0]        repeat_count;
	logic              image_end;
	logic              run_clamped;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [tgarle_pkg::ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	rle_pixel_board sb;
	int send_idle;
	int recv_stall;
	int hold_cycles;
	int quiet_cycles;

	// first two images: overlong repeat run, then raw and repeat packets and a pixel left half built
	logic [7:0] opening_bytes [18] = '{
		8'hFF, 8'h00, 8'hFF, 8'h80,
		8'h01, 8'hFF, 8'h00, 8'h7F, 8'h01, 8'h02, 8'h03,
		8'h80, 8'hAA, 8'hBB, 8'hCC,
		8'h00, 8'h10, 8'h20
	};
	logic [7:0] wide_bytes [4] = '{8'h01, 8'h80, 8'hFE, 8'h7F};

	tga_rle_pixel_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_value(pixel_value),
		.repeat_count(repeat_count),
		.image_end(image_end),
		.run_clamped(run_clamped),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, or a long hold-off when one is requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall);
			end
		end
	end

	// watch both channels at each edge; give up after a long quiet spell
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_pixel({pixel_value, repeat_count, image_end, run_clamped});
			end
			if (in_valid && !in_stall) begin
				sb.take_byte(data_byte);
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall) || (psel && penable && pready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// mostly packet heads with short runs where one is due, else random pixel bytes
	function automatic logic [7:0] pick_byte();
		logic [6:0] run;
		if ($urandom_range(99) < 10) return 8'($urandom);
		if (!sb.rle || !sb.head_due()) return 8'($urandom);
		run = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(7));
		if ($urandom_range(1) == 1) return tgarle_pkg::REPEAT_FLAG | {1'b0, run};
		return {1'b0, run};
	endfunction

	task automatic offer(input logic [7:0] b);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle) gap++;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending, wait for every pixel word, then let heads and partial pixels clear
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pixels_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reconfigure(input logic [2:0] bpp, input logic [31:0] total, input logic rle);
		settle();
		apb_write(tgarle_pkg::REG_BPP, {29'd0, bpp});
		apb_write(tgarle_pkg::REG_TOTAL, total);
		apb_write(tgarle_pkg::REG_RLE, {31'd0, rle});
	endtask

	task automatic run_phase(input logic [2:0] bpp, input logic [31:0] total, input logic rle,
			input int idle, input int stall, input int n);
		reconfigure(bpp, total, rle);
		send_idle = idle;
		recv_stall = stall;
		repeat (n) offer(pick_byte());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle = 0;
		recv_stall = 0;
		hold_cycles = 0;
		quiet_cycles = 0;
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: clamped repeat run, raw and repeat packets, depth change mid-pixel
		reconfigure(3'd3, 32'd4, 1'b1);
		foreach (opening_bytes[i]) offer(opening_bytes[i]);
		reconfigure(3'd2, 32'd4, 1'b1);
		offer(8'h30);
		// zero depth and zero image size, uncompressed
		reconfigure(3'd0, 32'd0, 1'b0);
		offer(8'h5A);
		// depth seven acts as four; image left open for the mode change that follows
		reconfigure(3'd7, 32'd2, 1'b0);
		foreach (wide_bytes[i]) offer(wide_bytes[i]);

		// random streams over several settings and idling patterns
		run_phase(3'd4, 32'd5, 1'b1, 0, 0, 80);
		run_phase(3'd3, 32'd17, 1'b1, 78, 0, 80);
		run_phase(3'd1, 32'd1, 1'b1, 0, 78, 80);
		run_phase(3'd2, 32'd40, 1'b0, 8, 8, 60);

		// long receiver hold-off so the decoder backs up, then a full pause mid-stream
		reconfigure(3'd4, 32'd200, 1'b1);
		send_idle = 0;
		recv_stall = 0;
		hold_cycles = HOLD_CYCLES;
		repeat (60) offer(pick_byte());
		settle();
		repeat (60) offer(pick_byte());

		run_phase(3'd5, 32'd0, 1'b1, 8, 8, 60);
		run_phase(3'd3, 32'd9, 1'b1, 0, 78, 60);
		// largest size last: this image never ends
		run_phase(3'd6, 32'hFFFF_FFFF, 1'b1, 78, 0, 60);

		settle();
		if (sb.mismatches == 0 && sb.pixels_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
